### src/rttc_pkg.sv
`default_nettype none

package rttc_pkg;

  localparam int CH_W         = 4;
  localparam int LEVEL_BITS   = 7;
  localparam int TEMP_W       = 8;
  localparam int MASK_W       = 10;
  localparam int PACK_W       = 63;
  localparam int PACK_FIELDS  = PACK_W / LEVEL_BITS;
  localparam int LOCK_W       = 8;
  localparam int ELAPSED_W    = 9;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 63;

  localparam int DEFAULT_NUM_CHANNELS       = 9;
  localparam int DEFAULT_FIRST_PUMP_CHANNEL = 3;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX     = '1;
  localparam logic [MASK_W-1:0]    AUTO_RESET      = '1;
  localparam logic [LOCK_W-1:0]    LOCKOUT_RESET   = 8'd60;
  localparam logic [TEMP_W-1:0]    FAN_LIMIT_RESET = 8'd35;

  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_SCHEDULE = 2'd1,
    CMD_MANUAL   = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACTIVE_MASK  = 3'd0,
    REG_AUTO_MASK    = 3'd1,
    REG_LOWER_LIMITS = 3'd2,
    REG_UPPER_LIMITS = 3'd3,
    REG_MAX_ON_TIMES = 3'd4,
    REG_LOCKOUT      = 3'd5,
    REG_FAN_LIMIT    = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [MASK_W-1:0] active_mask;
    logic [MASK_W-1:0] auto_mask;
    logic [PACK_W-1:0] lower_limits;
    logic [PACK_W-1:0] upper_limits;
    logic [PACK_W-1:0] max_on_times;
    logic [LOCK_W-1:0] lockout_seconds;
    logic [TEMP_W-1:0] fan_temp_limit;
  } cfg_t;

  typedef struct packed {
    logic                 relay;
    logic                 timing;
    logic [ELAPSED_W-1:0] elapsed;
    logic                 pending;
  } chan_st_t;

  typedef struct packed {
    logic     act_we;
    logic     fan_we;
    chan_st_t st;
    logic     fan_relay;
    logic     res_relay;
    logic     res_run;
  } rule_out_t;

  // Channels whose field would lie past the packed register read as zero.
  function automatic logic [LEVEL_BITS-1:0] field_of(input logic [PACK_W-1:0] packed_val,
                                                     input logic [CH_W-1:0] ch);
    logic [LEVEL_BITS-1:0] f;
    f = '0;
    for (int i = 0; i < PACK_FIELDS; i++) begin
      if (ch == CH_W'(i)) begin
        f = packed_val[i*LEVEL_BITS +: LEVEL_BITS];
      end
    end
    return f;
  endfunction

  function automatic logic mask_bit(input logic [MASK_W-1:0] m, input logic [CH_W:0] ch);
    logic b;
    b = 1'b0;
    for (int i = 0; i < MASK_W; i++) begin
      if (ch == (CH_W+1)'(i)) begin
        b = m[i];
      end
    end
    return b;
  endfunction

endpackage

`default_nettype wire

### src/rttc_cfg.sv
`default_nettype none

module rttc_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [rttc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rttc_pkg::CFG_DATA_W-1:0] cfg_data,
  output rttc_pkg::cfg_t                       cfg
);

  rttc_pkg::cfg_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        rttc_pkg::REG_ACTIVE_MASK:  cfg_nxt.active_mask     = cfg_data[rttc_pkg::MASK_W-1:0];
        rttc_pkg::REG_AUTO_MASK:    cfg_nxt.auto_mask       = cfg_data[rttc_pkg::MASK_W-1:0];
        rttc_pkg::REG_LOWER_LIMITS: cfg_nxt.lower_limits    = cfg_data[rttc_pkg::PACK_W-1:0];
        rttc_pkg::REG_UPPER_LIMITS: cfg_nxt.upper_limits    = cfg_data[rttc_pkg::PACK_W-1:0];
        rttc_pkg::REG_MAX_ON_TIMES: cfg_nxt.max_on_times    = cfg_data[rttc_pkg::PACK_W-1:0];
        rttc_pkg::REG_LOCKOUT:      cfg_nxt.lockout_seconds = cfg_data[rttc_pkg::LOCK_W-1:0];
        rttc_pkg::REG_FAN_LIMIT:    cfg_nxt.fan_temp_limit  = cfg_data[rttc_pkg::TEMP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.active_mask     <= '0;
      cfg_r.auto_mask       <= rttc_pkg::AUTO_RESET;
      cfg_r.lower_limits    <= '0;
      cfg_r.upper_limits    <= '0;
      cfg_r.max_on_times    <= '0;
      cfg_r.lockout_seconds <= rttc_pkg::LOCKOUT_RESET;
      cfg_r.fan_temp_limit  <= rttc_pkg::FAN_LIMIT_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

### src/rttc_rules.sv
`default_nettype none

module rttc_rules #(
  parameter int NUM_CHANNELS       = rttc_pkg::DEFAULT_NUM_CHANNELS,
  parameter int FIRST_PUMP_CHANNEL = rttc_pkg::DEFAULT_FIRST_PUMP_CHANNEL
) (
  input  wire rttc_pkg::cfg_t                     cfg,
  input  wire logic [1:0]                         command,
  input  wire logic [rttc_pkg::CH_W-1:0]          channel,
  input  wire logic [rttc_pkg::LEVEL_BITS-1:0]    sensor_level,
  input  wire logic signed [rttc_pkg::TEMP_W-1:0] air_temp,
  input  wire logic                               manual_on,
  input  wire rttc_pkg::chan_st_t                 cur,
  input  wire logic                               cur_fan_relay,
  output rttc_pkg::rule_out_t                     res
);

  localparam logic [rttc_pkg::CH_W:0] NUM_C  = (rttc_pkg::CH_W+1)'(NUM_CHANNELS);
  localparam logic [rttc_pkg::CH_W:0] PUMP_C = (rttc_pkg::CH_W+1)'(FIRST_PUMP_CHANNEL);
  localparam int SUM_W = rttc_pkg::ELAPSED_W + 1;

  logic [rttc_pkg::CH_W:0]       ch_x;
  logic                          is_act;
  logic                          is_fan;
  logic [rttc_pkg::LEVEL_BITS-1:0] max_on, lo_lim, hi_lim;
  logic [SUM_W-1:0]              end_limit;
  rttc_pkg::chan_st_t            st;
  logic                          fan_relay;

  assign ch_x      = {1'b0, channel};
  assign is_act    = ch_x < NUM_C;
  assign is_fan    = ch_x == NUM_C;
  assign max_on    = rttc_pkg::field_of(cfg.max_on_times, channel);
  assign lo_lim    = rttc_pkg::field_of(cfg.lower_limits, channel);
  assign hi_lim    = rttc_pkg::field_of(cfg.upper_limits, channel);
  assign end_limit = SUM_W'(max_on) + SUM_W'(cfg.lockout_seconds);

  always_comb begin
    st        = cur;
    fan_relay = cur_fan_relay;
    unique case (command)
      rttc_pkg::CMD_TICK: begin
        if (!rttc_pkg::mask_bit(cfg.active_mask, ch_x)) begin
          st.relay  = 1'b0;
          fan_relay = 1'b0;
        end else if (rttc_pkg::mask_bit(cfg.auto_mask, ch_x)) begin
          fan_relay = $signed(air_temp) > $signed(cfg.fan_temp_limit);
          if (cur.elapsed > rttc_pkg::ELAPSED_W'(max_on)) begin
            st.relay = 1'b0;
          end
          // A run starts only when no run or lockout is under way.
          if (sensor_level <= lo_lim) begin
            if (ch_x >= PUMP_C && !st.timing) begin
              st.timing = 1'b1;
              st.relay  = 1'b1;
            end
          end else if (sensor_level >= hi_lim) begin
            st.relay = 1'b0;
          end else if (cur.pending) begin
            if (!st.timing) begin
              st.timing = 1'b1;
              st.relay  = 1'b1;
            end
            st.pending = 1'b0;
          end
        end
        if (st.timing && st.elapsed < rttc_pkg::ELAPSED_MAX) begin
          st.elapsed = st.elapsed + 1'b1;
        end
        if (SUM_W'(st.elapsed) > end_limit) begin
          st.timing  = 1'b0;
          st.elapsed = '0;
        end
      end
      rttc_pkg::CMD_SCHEDULE: st.pending = 1'b1;
      rttc_pkg::CMD_MANUAL: begin
        st.relay  = manual_on;
        fan_relay = manual_on;
      end
      default: ;
    endcase
  end

  always_comb begin
    res.act_we    = is_act;
    res.fan_we    = is_fan;
    res.st        = st;
    res.fan_relay = fan_relay;
    res.res_relay = is_act ? st.relay : (is_fan ? fan_relay : 1'b0);
    res.res_run   = is_act ? st.timing : 1'b0;
  end

endmodule

`default_nettype wire

### src/relay_threshold_timer_control_core.sv
// A beat taken into the input register gets its result in the output register.
// Throughput: one beat per cycle unless results stall; each beat updates its
// channel state as it leaves the input register; same-channel beats may follow.
// The output register lets one more beat enter while a result waits.
// Reset (rst_n low at a clock edge) clears all channel state and valid flags
// and loads the configuration registers with their defaults.
`default_nettype none

module relay_threshold_timer_control_core #(
  parameter int NUM_CHANNELS       = rttc_pkg::DEFAULT_NUM_CHANNELS,
  parameter int FIRST_PUMP_CHANNEL = rttc_pkg::DEFAULT_FIRST_PUMP_CHANNEL
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [1:0]                         in_command,
  input  wire logic [rttc_pkg::CH_W-1:0]          in_channel,
  input  wire logic [rttc_pkg::LEVEL_BITS-1:0]    in_sensor_level,
  input  wire logic signed [rttc_pkg::TEMP_W-1:0] in_air_temp,
  input  wire logic                               in_manual_on,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [rttc_pkg::CH_W-1:0]               out_channel,
  output logic                                    out_relay_state,
  output logic                                    out_run_active,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [rttc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [rttc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  rttc_pkg::cfg_t      cfg;
  rttc_pkg::rule_out_t res;
  rttc_pkg::chan_st_t  cur;

  logic                                 in_valid_r;
  logic [1:0]                           in_command_r;
  logic [rttc_pkg::CH_W-1:0]            in_channel_r;
  logic [rttc_pkg::LEVEL_BITS-1:0]      in_sensor_level_r;
  logic signed [rttc_pkg::TEMP_W-1:0]   in_air_temp_r;
  logic                                 in_manual_on_r;

  rttc_pkg::chan_st_t                   chan_r [NUM_CHANNELS];
  logic                                 fan_relay_r;

  logic                                 out_valid_r;
  logic [rttc_pkg::CH_W-1:0]            out_channel_r;
  logic                                 out_relay_state_r;
  logic                                 out_run_active_r;

  logic advance;

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  assign out_valid       = out_valid_r;
  assign out_channel     = out_channel_r;
  assign out_relay_state = out_relay_state_r;
  assign out_run_active  = out_run_active_r;

  rttc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  always_comb begin
    cur = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if ({1'b0, in_channel_r} == (rttc_pkg::CH_W+1)'(i)) begin
        cur = chan_r[i];
      end
    end
  end

  rttc_rules #(
    .NUM_CHANNELS       (NUM_CHANNELS),
    .FIRST_PUMP_CHANNEL (FIRST_PUMP_CHANNEL)
  ) u_rules (
    .cfg           (cfg),
    .command       (in_command_r),
    .channel       (in_channel_r),
    .sensor_level  (in_sensor_level_r),
    .air_temp      (in_air_temp_r),
    .manual_on     (in_manual_on_r),
    .cur           (cur),
    .cur_fan_relay (fan_relay_r),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_command_r      <= in_command;
      in_channel_r      <= in_channel;
      in_sensor_level_r <= in_sensor_level;
      in_air_temp_r     <= in_air_temp;
      in_manual_on_r    <= in_manual_on;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        chan_r[i] <= '0;
      end
      fan_relay_r <= 1'b0;
    end else if (advance) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        if (res.act_we && {1'b0, in_channel_r} == (rttc_pkg::CH_W+1)'(i)) begin
          chan_r[i] <= res.st;
        end
      end
      if (res.fan_we) begin
        fan_relay_r <= res.fan_relay;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_channel_r     <= in_channel_r;
      out_relay_state_r <= res.res_relay;
      out_run_active_r  <= res.res_run;
    end
  end

endmodule

`default_nettype wire

### src/rttc_checker.sv
`default_nettype none

module rttc_checker #(
  parameter int NUM_CHANNELS = rttc_pkg::DEFAULT_NUM_CHANNELS
) (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic [rttc_pkg::CH_W-1:0] out_channel,
  input wire logic                      out_relay_state,
  input wire logic                      out_run_active
);

  localparam logic [rttc_pkg::CH_W:0] NUM_C = (rttc_pkg::CH_W+1)'(NUM_CHANNELS);

  // A stalled result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_channel)
      && $stable(out_relay_state) && $stable(out_run_active))
    else $error("result beat changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // The fan has no run timing.
  a_fan_no_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && {1'b0, out_channel} == NUM_C |-> !out_run_active)
    else $error("fan channel reports run timing");

  // Channels beyond the fan hold no state and report everything off.
  a_beyond_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && {1'b0, out_channel} > NUM_C |-> !out_relay_state && !out_run_active)
    else $error("channel beyond the fan reports a relay or run");

endmodule

bind relay_threshold_timer_control_core rttc_checker #(
  .NUM_CHANNELS (NUM_CHANNELS)
) u_rttc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_channel     (out_channel),
  .out_relay_state (out_relay_state),
  .out_run_active  (out_run_active)
);

`default_nettype wire

### dv/relay_threshold_timer_control_core_tb.sv
`default_nettype none

module relay_threshold_timer_control_core_tb;

  localparam int CH_W       = rttc_pkg::CH_W;
  localparam int LEVEL_BITS = rttc_pkg::LEVEL_BITS;
  localparam int TEMP_W     = rttc_pkg::TEMP_W;
  localparam int MASK_W     = rttc_pkg::MASK_W;
  localparam int PACK_W     = rttc_pkg::PACK_W;
  localparam int LOCK_W     = rttc_pkg::LOCK_W;
  localparam int ELAPSED_W  = rttc_pkg::ELAPSED_W;
  localparam int CFG_IDX_W  = rttc_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = rttc_pkg::CFG_DATA_W;

  localparam int N_CH         = rttc_pkg::DEFAULT_NUM_CHANNELS;
  localparam int FAN_CH       = N_CH;
  localparam int FIRST_PUMP   = rttc_pkg::DEFAULT_FIRST_PUMP_CHANNEL;
  localparam int NUM_REGS     = 7;
  localparam int IDLE_PCT     = 34;
  localparam int STALL_CYCLES = 60;
  localparam int PHASE_BEATS  = 220;
  localparam int DRAIN_CYCLES = 4;
  localparam int TIMEOUT      = 4000000;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]               command;
    logic [CH_W-1:0]          channel;
    logic [LEVEL_BITS-1:0]    level;
    logic signed [TEMP_W-1:0] temp;
    logic                     manual;
  } relay_beat_t;

  typedef struct {
    logic [CH_W-1:0] channel;
    logic            relay;
    logic            run;
  } relay_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [1:0]               in_command = rttc_pkg::CMD_TICK;
  logic [CH_W-1:0]          in_channel = '0;
  logic [LEVEL_BITS-1:0]    in_sensor_level = '0;
  logic signed [TEMP_W-1:0] in_air_temp = '0;
  logic                     in_manual_on = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [CH_W-1:0]          out_channel;
  logic                     out_relay_state;
  logic                     out_run_active;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = rttc_pkg::REG_ACTIVE_MASK;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;

  relay_threshold_timer_control_core i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_channel      (in_channel),
    .in_sensor_level (in_sensor_level),
    .in_air_temp     (in_air_temp),
    .in_manual_on    (in_manual_on),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_channel     (out_channel),
    .out_relay_state (out_relay_state),
    .out_run_active  (out_run_active),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the controller: configuration and per-channel state.
  logic [MASK_W-1:0]        p_active   = '0;
  logic [MASK_W-1:0]        p_auto     = rttc_pkg::AUTO_RESET;
  logic [PACK_W-1:0]        p_lower    = '0;
  logic [PACK_W-1:0]        p_upper    = '0;
  logic [PACK_W-1:0]        p_max_on   = '0;
  logic [LOCK_W-1:0]        p_lockout  = rttc_pkg::LOCKOUT_RESET;
  logic signed [TEMP_W-1:0] p_fan_limit = rttc_pkg::FAN_LIMIT_RESET;

  logic                 relay_q   [N_CH+1] = '{default: 1'b0};
  logic                 timing_q  [N_CH]   = '{default: 1'b0};
  logic [ELAPSED_W-1:0] elapsed_q [N_CH]   = '{default: '0};
  logic                 sched_q   [N_CH]   = '{default: 1'b0};

  relay_beat_t   pending_beats[$];
  relay_report_t expected_reports[$];
  relay_beat_t   bus_beat;
  relay_report_t want;
  logic [CFG_DATA_W-1:0] cfg_plan [NUM_REGS];

  int  beats_queued = 0;
  int  results_seen = 0;
  int  errors = 0;
  int  stall_left = 0;
  bit  hold_request = 1'b0;
  bit  sender_hold = 1'b0;
  bit  quiet = 1'b0;
  int  n_ticks = 0, n_sched = 0, n_manual = 0, n_other = 0;
  int  n_runs = 0, n_relay_on = 0, n_phases = 0;

  function automatic logic [LEVEL_BITS-1:0] threshold_of(input logic [PACK_W-1:0] packed_val,
                                                         input int c);
    return packed_val[c*LEVEL_BITS +: LEVEL_BITS];
  endfunction

  function automatic void begin_run(input int c);
    if (!timing_q[c]) begin
      timing_q[c] = 1'b1;
      relay_q[c] = 1'b1;
    end
  endfunction

  function automatic void tick_channel(input int c, input logic [LEVEL_BITS-1:0] level);
    logic [LEVEL_BITS-1:0] max_on;
    max_on = threshold_of(p_max_on, c);
    if (!p_active[c]) begin
      relay_q[c] = 1'b0;
    end else if (p_auto[c]) begin
      if (elapsed_q[c] > max_on) relay_q[c] = 1'b0;
      if (level <= threshold_of(p_lower, c)) begin
        if (c >= FIRST_PUMP) begin_run(c);
      end else if (level >= threshold_of(p_upper, c)) begin
        relay_q[c] = 1'b0;
      end else if (sched_q[c]) begin
        begin_run(c);
        sched_q[c] = 1'b0;
      end
    end
    // The run timer keeps counting whatever the mode of the channel.
    if (timing_q[c] && elapsed_q[c] != rttc_pkg::ELAPSED_MAX) begin
      elapsed_q[c] = elapsed_q[c] + 1'b1;
    end
    if (int'(elapsed_q[c]) > int'(max_on) + int'(p_lockout)) begin
      timing_q[c] = 1'b0;
      elapsed_q[c] = '0;
    end
  endfunction

  function automatic relay_report_t step_relays(input relay_beat_t b);
    relay_report_t r;
    int c;
    c = int'(b.channel);
    if (c < N_CH) begin
      case (b.command)
        rttc_pkg::CMD_TICK:     tick_channel(c, b.level);
        rttc_pkg::CMD_SCHEDULE: sched_q[c] = 1'b1;
        rttc_pkg::CMD_MANUAL:   relay_q[c] = b.manual;
        default: ;
      endcase
    end else if (c == FAN_CH) begin
      if (b.command == rttc_pkg::CMD_TICK) begin
        if (!p_active[FAN_CH]) relay_q[FAN_CH] = 1'b0;
        else if (p_auto[FAN_CH]) relay_q[FAN_CH] = (b.temp > p_fan_limit);
      end else if (b.command == rttc_pkg::CMD_MANUAL) begin
        relay_q[FAN_CH] = b.manual;
      end
    end
    r.channel = b.channel;
    r.relay = 1'b0;
    r.run = 1'b0;
    if (c <= FAN_CH) r.relay = relay_q[c];
    if (c < N_CH) r.run = timing_q[c];
    return r;
  endfunction

  function automatic void apply_reg(input rttc_pkg::cfg_reg_t idx,
                                    input logic [CFG_DATA_W-1:0] value);
    case (idx)
      rttc_pkg::REG_ACTIVE_MASK:  p_active = value[MASK_W-1:0];
      rttc_pkg::REG_AUTO_MASK:    p_auto = value[MASK_W-1:0];
      rttc_pkg::REG_LOWER_LIMITS: p_lower = value[PACK_W-1:0];
      rttc_pkg::REG_UPPER_LIMITS: p_upper = value[PACK_W-1:0];
      rttc_pkg::REG_MAX_ON_TIMES: p_max_on = value[PACK_W-1:0];
      rttc_pkg::REG_LOCKOUT:      p_lockout = value[LOCK_W-1:0];
      rttc_pkg::REG_FAN_LIMIT:    p_fan_limit = value[TEMP_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void enqueue(input relay_beat_t b);
    pending_beats.push_back(b);
    beats_queued++;
  endfunction

  function automatic void queue_beat(input logic [1:0] cmd, input int ch, input int lvl,
                                     input int tmp, input logic man);
    relay_beat_t b;
    b.command = cmd;
    b.channel = CH_W'(ch);
    b.level = LEVEL_BITS'(lvl);
    b.temp = TEMP_W'(tmp);
    b.manual = man;
    enqueue(b);
  endfunction

  function automatic logic [PACK_W-1:0] pack_fields(input int lo, input int hi);
    logic [PACK_W-1:0] v;
    v = '0;
    for (int i = 0; i < N_CH; i++) begin
      v[i*LEVEL_BITS +: LEVEL_BITS] = LEVEL_BITS'($urandom_range(hi, lo));
    end
    return v;
  endfunction

  // Levels often land just around the thresholds of the channel so that
  // every branch of the threshold rules is taken often.
  function automatic relay_beat_t rand_beat();
    relay_beat_t b;
    int pick, v;
    b.command = rttc_pkg::CMD_TICK;
    b.channel = CH_W'($urandom_range(N_CH - 1));
    b.level = LEVEL_BITS'($urandom);
    b.temp = TEMP_W'($urandom);
    b.manual = 1'($urandom);
    pick = $urandom_range(99);
    if (pick < 62) begin
      case ($urandom_range(2))
        0: v = int'(threshold_of(p_lower, b.channel)) + int'($urandom_range(4)) - 2;
        1: v = int'(threshold_of(p_upper, b.channel)) + int'($urandom_range(4)) - 2;
        default: v = $urandom_range(127);
      endcase
      if (v < 0) v = 0;
      if (v > 127) v = 127;
      b.level = LEVEL_BITS'(v);
    end else if (pick < 72) begin
      b.channel = CH_W'(FAN_CH);
      if ($urandom_range(1) == 0) begin
        v = int'(p_fan_limit) + int'($urandom_range(4)) - 2;
        if (v < -128) v = -128;
        if (v > 127) v = 127;
        b.temp = TEMP_W'(v);
      end
    end else if (pick < 82) begin
      b.command = rttc_pkg::CMD_SCHEDULE;
    end else if (pick < 90) begin
      b.command = rttc_pkg::CMD_MANUAL;
      b.channel = CH_W'($urandom_range(FAN_CH));
    end else begin
      case ($urandom_range(2))
        0: b.command = CMD_UNUSED;
        1: b.channel = CH_W'($urandom_range(15, FAN_CH + 1));
        default: begin
          b.command = rttc_pkg::CMD_SCHEDULE;
          b.channel = CH_W'(FAN_CH);
        end
      endcase
    end
    return b;
  endfunction

  // Input driver: a beat is presented as soon as the previous one is taken,
  // unless an idle cycle or a sender hold intervenes.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_reports.push_back(step_relays(bus_beat));
        case (bus_beat.command)
          rttc_pkg::CMD_TICK:     n_ticks++;
          rttc_pkg::CMD_SCHEDULE: n_sched++;
          rttc_pkg::CMD_MANUAL:   n_manual++;
          default:                n_other++;
        endcase
      end
      if (!in_valid || in_ready) begin
        if (pending_beats.size() != 0 && !sender_hold &&
            (quiet || $urandom_range(99) >= IDLE_PCT)) begin
          bus_beat = pending_beats.pop_front();
          in_valid <= 1'b1;
          in_command <= bus_beat.command;
          in_channel <= bus_beat.channel;
          in_sensor_level <= bus_beat.level;
          in_air_temp <= bus_beat.temp;
          in_manual_on <= bus_beat.manual;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver back-pressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          $error("result beat for channel %0d arrived with none expected", out_channel);
          errors++;
        end else begin
          want = expected_reports.pop_front();
          if (out_channel !== want.channel) begin
            $error("out_channel: expected %0d, got %0d", want.channel, out_channel);
            errors++;
          end
          if (out_relay_state !== want.relay) begin
            $error("relay_state: expected %0b, got %0b", want.relay, out_relay_state);
            errors++;
          end
          if (out_run_active !== want.run) begin
            $error("run_active: expected %0b, got %0b", want.run, out_run_active);
            errors++;
          end
          results_seen++;
          if (want.run) n_runs++;
          if (want.relay) n_relay_on++;
        end
      end
      if (hold_request) begin
        stall_left = STALL_CYCLES;
        hold_request = 1'b0;
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  task automatic load_config();
    for (int r = 0; r < NUM_REGS; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= rttc_pkg::cfg_reg_t'(r);
      cfg_data <= cfg_plan[r];
      do @(posedge clk); while (!cfg_ready);
      apply_reg(rttc_pkg::cfg_reg_t'(r), cfg_plan[r]);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
    n_phases++;
  endtask

  task automatic drain();
    while (results_seen != beats_queued) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset configuration: every channel is inactive, so ticks force relays off.
    queue_beat(rttc_pkg::CMD_MANUAL, 5, 0, 0, 1'b1);
    queue_beat(rttc_pkg::CMD_TICK, 5, 0, 0, 1'b0);
    queue_beat(rttc_pkg::CMD_TICK, 3, 0, 0, 1'b0);
    queue_beat(rttc_pkg::CMD_TICK, FAN_CH, 0, 125, 1'b0);
    drain();

    cfg_plan[rttc_pkg::REG_ACTIVE_MASK]  = '1;
    cfg_plan[rttc_pkg::REG_AUTO_MASK]    = CFG_DATA_W'(10'h3FB);
    cfg_plan[rttc_pkg::REG_LOWER_LIMITS] = {N_CH{7'd30}};
    cfg_plan[rttc_pkg::REG_UPPER_LIMITS] = {N_CH{7'd70}};
    cfg_plan[rttc_pkg::REG_MAX_ON_TIMES] = {N_CH{7'd2}};
    cfg_plan[rttc_pkg::REG_LOCKOUT]      = CFG_DATA_W'(8'd1);
    cfg_plan[rttc_pkg::REG_FAN_LIMIT]    = CFG_DATA_W'(8'd35);
    load_config();

    // A pump run: start, hold between thresholds, time out, lock out, restart.
    queue_beat(rttc_pkg::CMD_TICK, 3, 0, 0, 1'b0);
    queue_beat(rttc_pkg::CMD_TICK, 3, 50, 0, 1'b0);
    queue_beat(rttc_pkg::CMD_TICK, 3, 50, 0, 1'b0);
    queue_beat(rttc_pkg::CMD_TICK, 3, 50, 0, 1'b0);
    queue_beat(rttc_pkg::CMD_TICK, 3, 0, 0, 1'b0);
    // Below the low threshold a non-pump channel does not start.
    queue_beat(rttc_pkg::CMD_TICK, 0, 0, 0, 1'b0);
    queue_beat(rttc_pkg::CMD_SCHEDULE, 1, 0, 0, 1'b0);
    queue_beat(rttc_pkg::CMD_TICK, 1, 50, 0, 1'b0);
    queue_beat(rttc_pkg::CMD_TICK, 1, 100, 0, 1'b0);
    queue_beat(rttc_pkg::CMD_TICK, 4, 127, -128, 1'b1);
    // Channel 2 is in manual mode and keeps its written bit.
    queue_beat(rttc_pkg::CMD_MANUAL, 2, 0, 0, 1'b1);
    queue_beat(rttc_pkg::CMD_TICK, 2, 100, 0, 1'b0);
    queue_beat(rttc_pkg::CMD_MANUAL, 0, 0, 0, 1'b1);
    queue_beat(rttc_pkg::CMD_TICK, 0, 100, 0, 1'b0);
    queue_beat(rttc_pkg::CMD_TICK, FAN_CH, 0, 125, 1'b0);
    queue_beat(rttc_pkg::CMD_TICK, FAN_CH, 0, -40, 1'b0);
    queue_beat(rttc_pkg::CMD_TICK, FAN_CH, 0, 36, 1'b0);
    queue_beat(rttc_pkg::CMD_TICK, FAN_CH, 0, 35, 1'b0);
    queue_beat(rttc_pkg::CMD_MANUAL, FAN_CH, 0, 0, 1'b1);
    queue_beat(rttc_pkg::CMD_SCHEDULE, FAN_CH, 0, 0, 1'b0);
    queue_beat(rttc_pkg::CMD_TICK, 15, 127, 127, 1'b1);
    queue_beat(rttc_pkg::CMD_MANUAL, 12, 0, 0, 1'b1);
    queue_beat(CMD_UNUSED, 3, 0, 0, 1'b1);
    queue_beat(rttc_pkg::CMD_TICK, 8, 0, 0, 1'b0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 0) begin
        cfg_plan[rttc_pkg::REG_ACTIVE_MASK]  = '1;
        cfg_plan[rttc_pkg::REG_AUTO_MASK]    = '1;
        cfg_plan[rttc_pkg::REG_LOWER_LIMITS] = '1;
        cfg_plan[rttc_pkg::REG_UPPER_LIMITS] = '1;
        cfg_plan[rttc_pkg::REG_MAX_ON_TIMES] = '1;
        cfg_plan[rttc_pkg::REG_LOCKOUT]      = CFG_DATA_W'(8'hFF);
        cfg_plan[rttc_pkg::REG_FAN_LIMIT]    = CFG_DATA_W'(8'h7F);
      end else if (ph == 1) begin
        cfg_plan[rttc_pkg::REG_ACTIVE_MASK]  = CFG_DATA_W'(MASK_W'($urandom | $urandom));
        cfg_plan[rttc_pkg::REG_AUTO_MASK]    = CFG_DATA_W'(MASK_W'($urandom | $urandom));
        cfg_plan[rttc_pkg::REG_LOWER_LIMITS] = '0;
        cfg_plan[rttc_pkg::REG_UPPER_LIMITS] = '0;
        cfg_plan[rttc_pkg::REG_MAX_ON_TIMES] = '0;
        cfg_plan[rttc_pkg::REG_LOCKOUT]      = '0;
        cfg_plan[rttc_pkg::REG_FAN_LIMIT]    = CFG_DATA_W'(8'h80);
      end else begin
        cfg_plan[rttc_pkg::REG_ACTIVE_MASK]  = CFG_DATA_W'(MASK_W'($urandom | $urandom));
        cfg_plan[rttc_pkg::REG_AUTO_MASK]    =
          CFG_DATA_W'(MASK_W'($urandom | $urandom | $urandom));
        cfg_plan[rttc_pkg::REG_LOWER_LIMITS] = CFG_DATA_W'(pack_fields(0, 50));
        cfg_plan[rttc_pkg::REG_UPPER_LIMITS] = CFG_DATA_W'(pack_fields(40, 110));
        cfg_plan[rttc_pkg::REG_MAX_ON_TIMES] = CFG_DATA_W'(pack_fields(0, 6));
        cfg_plan[rttc_pkg::REG_LOCKOUT]      = CFG_DATA_W'(LOCK_W'($urandom_range(8)));
        cfg_plan[rttc_pkg::REG_FAN_LIMIT]    =
          CFG_DATA_W'(TEMP_W'(int'($urandom_range(60)) - 20));
      end
      load_config();
      quiet = (ph == 3);
      for (int n = 0; n < PHASE_BEATS; n++) enqueue(rand_beat());
      // Hold the result side long enough for the core to fill and stall.
      if (ph == 2) hold_request = 1'b1;
      if (ph == 4) begin
        while (pending_beats.size() > PHASE_BEATS / 2) @(posedge clk);
        sender_hold = 1'b1;
        @(posedge clk);
        while (in_valid || expected_reports.size() != 0) @(posedge clk);
        sender_hold = 1'b0;
      end
      drain();
      quiet = 1'b0;
    end

    if (expected_reports.size() != 0) begin
      $error("%0d expected results never arrived", expected_reports.size());
      errors++;
    end
    $display("Checked %0d result beats over %0d register settings: %0d ticks, %0d schedule",
             results_seen, n_phases, n_ticks, n_sched);
    $display("events, %0d manual writes, %0d other beats; %0d with relay on, %0d timing.",
             n_manual, n_other, n_relay_on, n_runs);
    if (errors == 0) begin
      $display("relay_threshold_timer_control_core test passed");
    end else begin
      $display("relay_threshold_timer_control_core test failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT);
    $display("relay_threshold_timer_control_core test failed");
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
src/rttc_pkg.sv
src/rttc_cfg.sv
src/rttc_rules.sv
src/relay_threshold_timer_control_core.sv
src/rttc_checker.sv
dv/relay_threshold_timer_control_core_tb.sv
